// ----- rtl/ffd_pkg.sv -----
// Shared constants and types for the feedback frame deframer.
// No dependencies; imported by ffd_frame_check, the deframer top level and the testbench.
package ffd_pkg;

  localparam logic [7:0] START_LO  = 8'hCD;
  localparam logic [7:0] START_HI  = 8'hAB;
  localparam int         FRAME_LEN = 16;
  localparam int         BODY_HELD = FRAME_LEN - 3;   // bytes 2..14 held before the last
  localparam int         NUM_WORDS = 6;                // payload words per frame

  localparam logic [3:0] POS_FIRST = 4'd2;
  localparam logic [3:0] POS_LAST  = 4'(FRAME_LEN - 1);
  localparam logic [7:0] RUN_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    PH_HUNT_LO = 2'd0,
    PH_HUNT_HI = 2'd1,
    PH_BODY    = 2'd2
  } phase_t;

  typedef logic [7:0] byte_t;
  typedef logic signed [15:0] word_t;

  // result of checking one complete frame
  typedef struct packed {
    logic  ok;
    word_t [NUM_WORDS-1:0] words;
  } check_t;

endpackage

// ----- rtl/ffd_in_if.sv -----
// Byte channel into the deframer: valid/ready handshake plus one received byte.
// Depends on nothing.
interface ffd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/ffd_out_if.sv -----
// Result channel from the deframer: valid/ready handshake plus decoded frame fields.
// Depends on nothing.
interface ffd_out_if;
  logic               valid;
  logic               ready;
  logic               checksum_ok;
  logic signed [15:0] command_one;
  logic signed [15:0] command_two;
  logic signed [15:0] speed_right;
  logic signed [15:0] speed_left;
  logic signed [15:0] battery_raw;
  logic signed [15:0] temperature_raw;
  logic [7:0]         bad_frame_count;

  modport source (output valid, output checksum_ok, output command_one, output command_two,
                  output speed_right, output speed_left, output battery_raw,
                  output temperature_raw, output bad_frame_count, input ready);
  modport sink   (input valid, input checksum_ok, input command_one, input command_two,
                  input speed_right, input speed_left, input battery_raw,
                  input temperature_raw, input bad_frame_count, output ready);
endinterface

// ----- rtl/ffd_frame_check.sv -----
// XOR-16 frame check: joins the held body bytes and the last byte into words,
// checks the XOR of start word and payload against the checksum word. Uses ffd_pkg.
module ffd_frame_check
  import ffd_pkg::*;
(
  input  byte_t  body [BODY_HELD],
  input  byte_t  last_byte,
  output check_t check
);

  logic [15:0] words [NUM_WORDS];
  logic [15:0] calc;
  logic [15:0] sum_word;

  always_comb begin
    calc = {START_HI, START_LO};
    for (int k = 0; k < NUM_WORDS; k++) begin
      words[k] = {body[2*k+1], body[2*k]};
      calc     = calc ^ words[k];
    end
    sum_word = {last_byte, body[BODY_HELD-1]};
    check.ok = (calc == sum_word);
    // payload is forced to zero on a bad frame
    for (int k = 0; k < NUM_WORDS; k++) begin
      check.words[k] = check.ok ? word_t'(words[k]) : '0;
    end
  end

endmodule

// ----- rtl/feedback_frame_deframer.sv -----
// Feedback frame deframer top level: start-word hunt, body collection, result register.
// Uses ffd_pkg, ffd_in_if, ffd_out_if and ffd_frame_check.
//
// Usage
//   rx : one received serial byte per item. The block hunts for the start word
//        0xABCD sent low byte first (CD then AB); a repeated CD keeps the hunt
//        armed, any other byte restarts it. The next 14 bytes complete a
//        16-byte frame of eight little-endian words.
//   fb : one item per complete frame, on its 16th byte: checksum status, six
//        signed payload words (zero when the check fails) and the run of
//        consecutive bad frames, saturating at 255 and cleared by a good frame.
// Output timing and throughput
//   The result appears in the output register in the cycle after the last frame
//   byte is taken. A byte is taken every cycle; the only limit is the single
//   output register, which takes a new result in the same cycle as the held
//   one leaves.
// Reset (rst, synchronous, active high)
//   Back to the hunt for CD, bad-frame run cleared, output empty. Held body
//   bytes are not cleared; they are always rewritten before a frame is checked.
// Stalls
//   While a result waits and fb.ready is low, rx.ready is low, so no byte is
//   lost and the result holds steady.
module feedback_frame_deframer
  import ffd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ffd_in_if.sink           rx,
  ffd_out_if.source        fb
);

  phase_t     phase, phase_next;
  logic [3:0] pos, pos_next;
  byte_t      body [BODY_HELD];
  logic [7:0] err_run;
  logic [7:0] err_run_next;
  logic       take;
  logic       frame_end;
  check_t     check;

  // output register can refill in the cycle it is emptied
  assign rx.ready  = !fb.valid || fb.ready;
  assign take      = rx.valid && rx.ready;
  assign frame_end = (phase == PH_BODY) && (pos == POS_LAST);

  ffd_frame_check u_check (
    .body      (body),
    .last_byte (rx.rx_byte),
    .check     (check)
  );

  // hunt / collect sequencing
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    unique case (phase)
      PH_HUNT_HI: begin
        if (rx.rx_byte == START_HI) begin
          phase_next = PH_BODY;
          pos_next   = POS_FIRST;
        end else if (rx.rx_byte == START_LO) begin
          phase_next = PH_HUNT_HI;
        end else begin
          phase_next = PH_HUNT_LO;
        end
      end
      PH_BODY: begin
        if (frame_end) begin
          phase_next = PH_HUNT_LO;
          pos_next   = POS_FIRST;
        end else begin
          pos_next   = pos + 4'd1;
        end
      end
      default: begin
        phase_next = (rx.rx_byte == START_LO) ? PH_HUNT_HI : PH_HUNT_LO;
      end
    endcase
  end

  // bad-frame run, saturating
  always_comb begin
    if (check.ok) begin
      err_run_next = '0;
    end else if (err_run != RUN_MAX) begin
      err_run_next = err_run + 8'd1;
    end else begin
      err_run_next = err_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT_LO;
      pos     <= POS_FIRST;
      err_run <= '0;
    end else if (take) begin
      phase <= phase_next;
      pos   <= pos_next;
      if (frame_end) begin
        err_run <= err_run_next;
      end
    end
  end

  // body bytes 2..14 shift in; the last byte goes straight to the check
  always_ff @(posedge clk) begin
    if (take && (phase == PH_BODY) && !frame_end) begin
      for (int i = 0; i < BODY_HELD - 1; i++) begin
        body[i] <= body[i+1];
      end
      body[BODY_HELD-1] <= rx.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fb.valid <= 1'b0;
    end else if (rx.ready) begin
      fb.valid <= take && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame_end) begin
      fb.checksum_ok     <= check.ok;
      fb.command_one     <= check.words[0];
      fb.command_two     <= check.words[1];
      fb.speed_right     <= check.words[2];
      fb.speed_left      <= check.words[3];
      fb.battery_raw     <= check.words[4];
      fb.temperature_raw <= check.words[5];
      fb.bad_frame_count <= err_run_next;
    end
  end

  // ---- checks ----
  a_result_from_body: assert property (@(posedge clk) disable iff (rst)
    $rose(fb.valid) |-> $past(phase) == PH_BODY && $past(pos) == POS_LAST)
    else $error("result without a completed frame");

  a_good_clears_run: assert property (@(posedge clk) disable iff (rst)
    fb.valid && fb.checksum_ok |-> fb.bad_frame_count == 8'd0)
    else $error("good frame with nonzero bad-frame run");

  a_bad_zero_payload: assert property (@(posedge clk) disable iff (rst)
    fb.valid && !fb.checksum_ok |-> fb.bad_frame_count != 8'd0 &&
      fb.command_one == 16'sd0 && fb.command_two == 16'sd0 &&
      fb.speed_right == 16'sd0 && fb.speed_left == 16'sd0 &&
      fb.battery_raw == 16'sd0 && fb.temperature_raw == 16'sd0)
    else $error("bad frame with payload or zero run");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> pos >= POS_FIRST)
    else $error("body position out of range");

  a_frame_restarts_hunt: assert property (@(posedge clk) disable iff (rst)
    take && frame_end |=> phase == PH_HUNT_LO && fb.valid)
    else $error("frame end did not return to hunt with a result");

endmodule

// ----- test/feedback_frame_deframer_tb.sv -----
// Self-checking testbench for feedback_frame_deframer: byte stream in, frame reports out.
// Depends on ffd_pkg, ffd_in_if, ffd_out_if and the deframer RTL.
// Predicts each report from the accepted bytes and checks the output field by field.
module feedback_frame_deframer_tb
  import ffd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES   = 1150;   // frame bytes in the random stream
  localparam int BAD_RUN_FRAMES = 40;     // bad frames in a row before a good one
  localparam int DRAIN_LIMIT    = 2000;   // cycles allowed for reports to come out
  localparam int SETTLE_CYCLES  = 4;      // idle margin after the last report

  typedef logic [5:0][15:0] payload_t;

  // one decoded frame as the block reports it
  typedef struct packed {
    logic     ok;
    payload_t words;
    byte_t    count;
  } frame_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffd_in_if  rx ();
  ffd_out_if fb ();

  feedback_frame_deframer u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .fb  (fb)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Runaway guard: far beyond the slowest legal run
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the hunt, the held body and the bad run
  // ---------------------------------------------------------------------------
  phase_t        hunt;
  int            body_pos;
  byte_t         body_bytes [FRAME_LEN-2];
  byte_t         bad_run;
  frame_report_t pending_frames [$];
  int            mismatches;
  bit            steady;   // when set, neither side idles

  // Mostly back to back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the predictor by one accepted byte; a finished frame queues a report
  task automatic track_byte(input byte_t b);
    logic [15:0]   calc;
    frame_report_t rep;
    case (hunt)
      PH_HUNT_HI: begin
        if (b == START_HI) begin
          hunt     = PH_BODY;
          body_pos = 2;
        end else if (b == START_LO) begin
          hunt = PH_HUNT_HI;
        end else begin
          hunt = PH_HUNT_LO;
        end
      end
      PH_BODY: begin
        body_bytes[body_pos-2] = b;
        body_pos++;
        if (body_pos == FRAME_LEN) begin
          hunt     = PH_HUNT_LO;
          body_pos = 0;
          // XOR of the start word and the six payload words against the last word
          calc = {START_HI, START_LO};
          for (int k = 0; k < NUM_WORDS; k++) begin
            rep.words[k] = {body_bytes[2*k+1], body_bytes[2*k]};
            calc ^= rep.words[k];
          end
          rep.ok = (calc == {body_bytes[13], body_bytes[12]});
          if (rep.ok) begin
            bad_run = '0;
          end else if (bad_run != RUN_MAX) begin
            bad_run++;
          end
          if (!rep.ok) rep.words = '0;
          rep.count = bad_run;
          pending_frames.push_back(rep);
        end
      end
      default: begin
        // the unused phase falls back into the hunt like phase 0
        hunt = (b == START_LO) ? PH_HUNT_HI : PH_HUNT_LO;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: drive at the falling edge, take the handshake at the rising one
  // ---------------------------------------------------------------------------
  task automatic send_byte(input byte_t b);
    int unsigned g;
    g = pick_gap();
    @(negedge clk);
    if (g != 0) begin
      rx.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    rx.valid   = 1'b1;
    rx.rx_byte = b;
    do @(posedge clk); while (rx.ready !== 1'b1);
    track_byte(b);
  endtask

  // Whole frame: start word, six payload words, then a checksum that is
  // right or deliberately spoiled
  task automatic send_frame(input payload_t pay, input bit good);
    logic [15:0] chk;
    chk = {START_HI, START_LO};
    for (int k = 0; k < NUM_WORDS; k++) chk ^= pay[k];
    if (!good) chk ^= 16'($urandom_range(1, 16'hFFFF));
    send_byte(START_LO);
    send_byte(START_HI);
    for (int k = 0; k < NUM_WORDS; k++) begin
      send_byte(pay[k][7:0]);
      send_byte(pay[k][15:8]);
    end
    send_byte(chk[7:0]);
    send_byte(chk[15:8]);
  endtask

  // Payload words, now and then pinned to the signed extremes
  function automatic payload_t rand_payload();
    payload_t p;
    for (int k = 0; k < NUM_WORDS; k++) begin
      case ($urandom_range(0, 9))
        0:       p[k] = 16'h8000;
        1:       p[k] = 16'h7FFF;
        2:       p[k] = 16'h0000;
        3:       p[k] = 16'hFFFF;
        default: p[k] = 16'($urandom);
      endcase
    end
    return p;
  endfunction

  // Stop sending, let every expected report out, then let the pipe settle
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    rx.valid = 1'b0;
    while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_frames.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected frame reports never arrived", $time,
               pending_frames.size());
      pending_frames.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Report receiver: random back-pressure, one assignment per falling edge
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    fb.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        fb.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      fb.ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want_v, got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
    end
  endtask

  // Every taken report is held against the oldest prediction
  always @(posedge clk) begin : check_reports
    frame_report_t want;
    payload_t      got;
    string         word_names [NUM_WORDS];
    word_names = '{"command_one", "command_two", "speed_right",
                   "speed_left", "battery_raw", "temperature_raw"};
    if (!rst && fb.valid === 1'b1 && fb.ready === 1'b1) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected frame report, ok %b count %0d", $time,
                 fb.checksum_ok, fb.bad_frame_count);
      end else begin
        want = pending_frames.pop_front();
        got  = {fb.temperature_raw, fb.battery_raw, fb.speed_left,
                fb.speed_right, fb.command_two, fb.command_one};
        check_field("checksum_ok", 16'(want.ok), 16'(fb.checksum_ok));
        for (int k = 0; k < NUM_WORDS; k++) check_field(word_names[k], want.words[k], got[k]);
        check_field("bad_frame_count", 16'(want.count), 16'(fb.bad_frame_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Good frame carrying the signed extremes and their neighbours
  task automatic test_good_extremes();
    send_frame({16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 1'b1);
    drain_results();
  endtask

  // Stray AB while hunting, a broken start word, then a repeated CD ahead of
  // a bad frame whose payload must come back zeroed
  task automatic test_start_hunt();
    send_byte(START_HI);
    send_byte(START_LO);
    send_byte(8'h12);
    send_byte(START_LO);
    send_frame({16'h1234, 16'hFEDC, 16'h7FFF, 16'h8000, 16'h5A5A, 16'hA5A5}, 1'b0);
    drain_results();
  endtask

  // A long run of bad frames counting up, then a good frame to clear it and
  // a bad one to start counting again
  task automatic test_bad_run();
    steady = 1'b1;
    repeat (BAD_RUN_FRAMES) send_frame(rand_payload(), 1'b0);
    send_frame(rand_payload(), 1'b1);
    send_frame(rand_payload(), 1'b0);
    steady = 1'b0;
    drain_results();
  endtask

  // Mostly well-formed frames, with repeated and broken start words and noise
  task automatic test_random_stream();
    int    sent;
    int    frames;
    byte_t b;
    sent   = 0;
    frames = 0;
    while (sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0: begin
          // repeated start byte ahead of a frame
          repeat ($urandom_range(1, 3)) send_byte(START_LO);
          send_frame(rand_payload(), $urandom_range(0, 3) != 0);
          sent += FRAME_LEN;
        end
        1: begin
          // broken start word
          do b = byte_t'($urandom); while (b == START_HI || b == START_LO);
          send_byte(START_LO);
          send_byte(b);
        end
        2: begin
          // line noise; may happen to hold start bytes, which is fine
          repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom));
        end
        default: begin
          send_frame(rand_payload(), $urandom_range(0, 3) != 0);
          sent += FRAME_LEN;
        end
      endcase
      frames++;
      if (frames % 20 == 0) begin
        // change the idling pattern and sometimes hold off until all is out
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) drain_results();
      end
    end
    steady = 1'b0;
    drain_results();
  endtask

  initial begin
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    hunt       = PH_HUNT_LO;
    body_pos   = 0;
    bad_run    = '0;
    mismatches = 0;
    steady     = 1'b0;
    for (int i = 0; i < FRAME_LEN - 2; i++) body_bytes[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_good_extremes();
    test_start_hunt();
    test_bad_run();
    test_random_stream();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
